// ----- design/pida_pkg.sv -----
// Package for the positional insert/delete array.
// Holds command, status and cell-operation codes and the cell control struct.
// No dependencies.
`default_nettype none

package pida_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 8;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;
  // wide enough to index and count any supported capacity (up to 1024)
  localparam int KEY_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [KEY_W-1:0]   key;
    logic [WORD_W-1:0]  wdata;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/positional_insert_delete_array.sv -----
// Top level of the positional insert/delete array: command decode, count, result register.
// Depends on pida_pkg and pida_row.
//
//  channel  | port group           | fields (low bit first)
//  ---------+----------------------+-------------------------------------------
//  command  | in_tvalid/tready     | command[1:0], position[9:2], value[41:10]
//  result   | out_tvalid/tready    | read_value[31:0], count[39:32], status[41:40]
//
// One item per cycle: every cell shifts in parallel in the cycle the item is
// accepted, and the result lands in the output register on the next edge.
// Reset clears the count and the output valid; cell contents are left as is.
// A held result stalls input only while out_tready is low.
`default_nettype none

module positional_insert_delete_array
  import pida_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // command[1:0], position[9:2], value[41:10]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata   // read_value[31:0], count[39:32], status[41:40]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = KEY_W + 1;

  cmd_t              cmd;
  logic [POS_W-1:0]  pos;
  logic [WORD_W-1:0] wval;
  logic              accept;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] out_rd_r;
  logic [WORD_W-1:0] out_rd_nxt;
  logic [POS_W-1:0]  out_cnt_r;
  logic [POS_W-1:0]  out_cnt_nxt;
  status_t           out_st_r;
  status_t           out_st_nxt;

  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic              full;
  logic              empty;
  status_t           st;
  cell_ctl_t         ctl;
  logic [WORD_W-1:0] rd_data;
  logic [CNT_W+POS_W-1:0] cnt_wide;

  assign cmd  = cmd_t'(in_tdata[1:0]);
  assign pos  = in_tdata[9:2];
  assign wval = in_tdata[41:10];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign pos_x = CMP_W'(pos);
  assign cnt_x = CMP_W'(count_r);
  assign full  = (cnt_x == CMP_W'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    st = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else if (pos == '0 || pos_x > cnt_x + CMP_W'(1)) begin
          st = ST_RANGE;
        end
      end
      CMD_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end
      end
      CMD_DELETE, CMD_READ: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos == '0 || pos_x > cnt_x) begin
          st = ST_RANGE;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // cell control: key is the 0-based slot, or the count for append
  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.key   = KEY_W'(pos) - KEY_W'(1);
    ctl.wdata = wval;
    count_nxt = count_r;
    if (cmd == CMD_APPEND) begin
      ctl.key = KEY_W'(count_r);
    end
    if (accept && st == ST_OK) begin
      case (cmd)
        CMD_INSERT: begin
          ctl.op    = CELL_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
        CMD_DELETE: begin
          ctl.op    = CELL_DELETE;
          count_nxt = count_r - CNT_W'(1);
        end
        CMD_APPEND: begin
          ctl.op    = CELL_WRITE;
          count_nxt = count_r + CNT_W'(1);
        end
        default: begin
          ctl.op = CELL_HOLD;
        end
      endcase
    end
  end

  pida_row #(
    .CAPACITY(CAPACITY)
  ) u_row (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data)
  );

  assign cnt_wide = {{POS_W{1'b0}}, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_rd_nxt    = (cmd == CMD_READ && st == ST_OK) ? rd_data : '0;
      out_cnt_nxt   = cnt_wide[POS_W-1:0];
      out_st_nxt    = st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rd_r  <= out_rd_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_st_r, out_cnt_r, out_rd_r};

endmodule

`default_nettype wire

// ----- design/pida_cell.sv -----
// One storage cell of the element row: holds one word and shifts with its neighbors.
// Depends on pida_pkg.
`default_nettype none

module pida_cell
  import pida_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [WORD_W-1:0] prev_val,
  input  wire logic [WORD_W-1:0] next_val,
  output logic      [WORD_W-1:0] val,
  output logic      [WORD_W-1:0] rd_val
);

  localparam logic [KEY_W-1:0] IDX = KEY_W'(INDEX);

  logic [WORD_W-1:0] val_r;
  logic [WORD_W-1:0] val_nxt;
  logic              hit;
  logic              above;

  assign hit   = (ctl.key == IDX);
  assign above = (IDX > ctl.key);

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (hit) begin
          val_nxt = ctl.wdata;
        end else if (above) begin
          val_nxt = prev_val;
        end
      end
      CELL_DELETE: begin
        if (hit || above) begin
          val_nxt = next_val;
        end
      end
      CELL_WRITE: begin
        if (hit) begin
          val_nxt = ctl.wdata;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  assign rd_val = hit ? val_r : '0;

endmodule

`default_nettype wire

// ----- design/pida_row.sv -----
// Row of storage cells chained to their neighbors, plus the read gather.
// Depends on pida_pkg and pida_cell.
`default_nettype none

module pida_row
  import pida_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] vals  [CAPACITY];
  logic [WORD_W-1:0] rds   [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] prev_v;
    logic [WORD_W-1:0] next_v;

    if (g == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_mid_p
      assign prev_v = vals[g-1];
    end
    // last cell keeps its own word on delete
    if (g == CAPACITY - 1) begin : g_last
      assign next_v = vals[g];
    end else begin : g_mid_n
      assign next_v = vals[g+1];
    end

    pida_cell #(
      .INDEX(g)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (vals[g]),
      .rd_val   (rds[g])
    );
  end

  // at most one cell matches the key, so an OR collects the read word
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | rds[i];
    end
  end

endmodule

`default_nettype wire
